>>> sv/psc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_pkg: shared constants and helpers for pressure sensor compensation
// fixed-point format, split multiplier sizes, register indexes, truncation
// ----------------------------------------------------------------------------
package psc_pkg;

  // fixed-point fraction bits of every intermediate
  localparam int FRAC_BITS = 24;

  // port widths
  localparam int RAW_W      = 24;
  localparam int TEMP_W     = 17;
  localparam int PRESS_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // split multiplier: x by y, y cut in a low and a high half
  localparam int MUL_X_W   = 33;
  localparam int MUL_Y_W   = 48;
  localparam int MUL_SPLIT = 24;
  localparam int MUL_P_W   = MUL_X_W + MUL_Y_W;
  localparam int TRUNC_W   = MUL_P_W - FRAC_BITS;

  // reciprocal of 127 for the pressure scaling divide
  localparam int          RECIP_SHIFT = 34;
  localparam int          RECIP_W     = 28;
  localparam logic [RECIP_W-1:0] RECIP_127 = RECIP_W'((64'd1 << RECIP_SHIFT) / 127);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_COEF           = 3'd0,
    REG_PRESS_OFFSET        = 3'd1,
    REG_PRESS_TEMP_GAIN     = 3'd2,
    REG_PRESS_CROSS_GAIN    = 3'd3,
    REG_PRESS_SQUARE_GAIN   = 3'd4,
    REG_PRESS_CROSS_SQ_GAIN = 3'd5,
    REG_PRESS_CUBE_GAIN     = 3'd6
  } cfg_reg_t;

  // drop the fraction bits, rounding toward zero
  function automatic logic signed [TRUNC_W-1:0] trunc_frac(
    input logic signed [MUL_P_W-1:0] x
  );
    logic signed [MUL_P_W-1:0] fl;
    logic                      rnd;
    fl  = x >>> FRAC_BITS;
    rnd = x[MUL_P_W-1] && (x[FRAC_BITS-1:0] != '0);
    return fl[TRUNC_W-1:0] + TRUNC_W'(rnd);
  endfunction

endpackage

>>> sv/psc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psc_mul: two-stage signed multiplier
// partial products of x with both halves of y, then the shifted sum
// ----------------------------------------------------------------------------
module psc_mul (
  input  logic                                  clk,
  input  logic                                  en_a,
  input  logic                                  en_b,
  input  logic signed [psc_pkg::MUL_X_W-1:0]    x,
  input  logic signed [psc_pkg::MUL_Y_W-1:0]    y,
  output logic signed [psc_pkg::MUL_P_W-1:0]    prod
);
  import psc_pkg::*;

  localparam int LO_P_W = MUL_X_W + MUL_SPLIT + 1;
  localparam int HI_W   = MUL_Y_W - MUL_SPLIT;
  localparam int HI_P_W = MUL_X_W + HI_W;

  logic signed [MUL_SPLIT:0]   y_lo;
  logic signed [HI_W-1:0]      y_hi;
  logic signed [LO_P_W-1:0]    lo_r;
  logic signed [HI_P_W-1:0]    hi_r;
  logic signed [MUL_P_W-1:0]   prod_nxt;
  logic signed [MUL_P_W-1:0]   prod_r;

  // low half is unsigned, high half carries the sign
  assign y_lo = $signed({1'b0, y[MUL_SPLIT-1:0]});
  assign y_hi = y[MUL_Y_W-1:MUL_SPLIT];

  assign prod_nxt = (MUL_P_W'(hi_r) <<< MUL_SPLIT) + MUL_P_W'(lo_r);

  always_ff @(posedge clk) begin
    if (en_a) begin
      lo_r <= x * y_lo;
      hi_r <= x * y_hi;
    end
    if (en_b) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

>>> sv/pressure_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_sensor_compensation: barometer calibration polynomial
// compensated temperature and saturated compensated pressure; without stalls, one word per clock
// ----------------------------------------------------------------------------
//
// channel  direction  handshake            payload
// cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in         in_valid/in_ready    in_raw_temperature, in_raw_pressure
// out      out        out_valid/out_ready  out_temperature, out_pressure,
//                                          out_pressure_clipped
//
// - 13 pipeline stages plus the output register; a new word can enter every
//   cycle while out is not stalled
// - the stage count is set by the pressure chain: scaling of p by a reciprocal
//   over stages 1 to 4, then three dependent multiplies (c30*p, p*a, p*b),
//   the last two each split in two halves over two stages
// - every stage holds its word on a stall and loads when it is empty or its
//   successor moves, so bubbles are squeezed out and in_ready stays high while
//   any stage is free
// - rst_n (synchronous) clears stage valid bits, out_valid and all
//   calibration registers; cfg_ready is always high
//
module pressure_sensor_compensation (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [psc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]         cfg_data,
  // raw sample channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [psc_pkg::RAW_W-1:0]              in_raw_temperature,
  input  logic [psc_pkg::RAW_W-1:0]              in_raw_pressure,
  // compensated result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [psc_pkg::TEMP_W-1:0]      out_temperature,
  output logic signed [psc_pkg::PRESS_W-1:0]     out_pressure,
  output logic                                   out_pressure_clipped
);
  import psc_pkg::*;

  localparam int NSTG    = 13;
  localparam int T_W     = RAW_W + FRAC_BITS - 19;      // scaled temperature
  localparam int T_SHIFT = FRAC_BITS - 19;
  localparam int Y_W     = 28;                          // pressure magnitude
  localparam int P_SHIFT = FRAC_BITS - 20;
  localparam int Q_W     = 21;                          // quotient by 127
  localparam int P_W     = Y_W + 1;                     // signed scaled pressure
  localparam int TF_W    = 41;                          // temperature accumulator
  localparam int CP_W    = 45;                          // 16-bit gain times t or p
  localparam int TPF_W   = T_W + P_W;                   // full t*p
  localparam int A_W     = 44;                          // a and f terms
  localparam int TP_W    = 33;                          // truncated t*p
  localparam int B_W     = 48;
  localparam int G_W     = 52;
  localparam int D_W     = 52;
  localparam int SUM_W   = 54;
  localparam int PI_W    = 33;

  localparam logic signed [PI_W-1:0] PI_MAX = PI_W'(64'sd2147483647);
  localparam logic signed [PI_W-1:0] PI_MIN = -PI_W'(64'sd2147483648);

  // --------------------------------------------------------------------------
  // calibration registers
  // --------------------------------------------------------------------------
  logic [23:0]        temp_coef_r;
  logic [39:0]        press_offset_r;
  logic signed [15:0] c01_r;
  logic signed [15:0] c11_r;
  logic signed [15:0] c20_r;
  logic signed [15:0] c21_r;
  logic signed [15:0] c30_r;

  assign cfg_ready = 1'b1;

  // writes to an index beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coef_r    <= '0;
      press_offset_r <= '0;
      c01_r          <= '0;
      c11_r          <= '0;
      c20_r          <= '0;
      c21_r          <= '0;
      c30_r          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEMP_COEF:           temp_coef_r    <= cfg_data[23:0];
        REG_PRESS_OFFSET:        press_offset_r <= cfg_data[39:0];
        REG_PRESS_TEMP_GAIN:     c01_r          <= cfg_data[15:0];
        REG_PRESS_CROSS_GAIN:    c11_r          <= cfg_data[15:0];
        REG_PRESS_SQUARE_GAIN:   c20_r          <= cfg_data[15:0];
        REG_PRESS_CROSS_SQ_GAIN: c21_r          <= cfg_data[15:0];
        REG_PRESS_CUBE_GAIN:     c30_r          <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // unpack the packed words into signed coefficients
  logic signed [11:0] c0;
  logic signed [11:0] c1;
  logic signed [19:0] c00;
  logic signed [19:0] c10;

  assign c0  = temp_coef_r[23:12];
  assign c1  = temp_coef_r[11:0];
  assign c00 = press_offset_r[39:20];
  assign c10 = press_offset_r[19:0];

  // --------------------------------------------------------------------------
  // pipeline control: stage i loads when empty or when stage i+1 loads
  // --------------------------------------------------------------------------
  logic [NSTG:1]   v_r;
  logic [NSTG+1:1] adv;
  logic            out_valid_r;

  always_comb begin
    adv[NSTG+1] = !out_valid_r || out_ready;
    for (int i = NSTG; i >= 1; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv[1]) begin
        v_r[1] <= in_valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
      if (adv[NSTG+1]) begin
        out_valid_r <= v_r[NSTG];
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  logic signed [T_W-1:0]    t_pipe_r    [1:4];
  logic [Y_W-1:0]           y_pipe_r    [1:3];
  logic                     pneg_pipe_r [1:3];
  logic [Q_W-1:0]           s2_q0_r;
  logic [Q_W-1:0]           s3_q_r;
  logic signed [TF_W-1:0]   s2_tf_r;
  logic signed [TEMP_W-1:0] temp_pipe_r [3:NSTG];
  logic signed [P_W-1:0]    p_pipe_r    [4:9];
  logic signed [CP_W-1:0]   s5_ca_r;
  logic signed [CP_W-1:0]   s5_cf_r;
  logic signed [TPF_W-1:0]  s5_tpf_r;
  logic signed [CP_W-1:0]   e_pipe_r    [5:12];
  logic signed [A_W-1:0]    s6_a_r;
  logic signed [A_W-1:0]    s6_f_r;
  logic signed [TP_W-1:0]   s6_tp_r;
  logic signed [B_W-1:0]    s9_b_r;
  logic signed [G_W-1:0]    g_pipe_r    [9:12];
  logic signed [D_W-1:0]    s12_d_r;
  logic signed [SUM_W-1:0]  s13_sum_r;

  // stage 1: sign-extend, scale temperature, take pressure magnitude
  logic signed [RAW_W-1:0]  traw;
  logic [RAW_W-1:0]         pabs;
  logic signed [T_W-1:0]    t_nxt;
  logic [Y_W-1:0]           y_nxt;

  assign traw  = in_raw_temperature;
  assign t_nxt = T_W'(traw) <<< T_SHIFT;
  assign pabs  = in_raw_pressure[RAW_W-1] ? (~in_raw_pressure + RAW_W'(1))
                                          : in_raw_pressure;
  // |p| = m * 2048 / 127 = 16m + floor(16m / 127)
  assign y_nxt = Y_W'(pabs) << P_SHIFT;

  // stage 2: quotient estimate by reciprocal, temperature accumulate
  logic [Y_W+RECIP_W-1:0]  recip_prod;
  logic signed [TF_W-1:0]  tf_nxt;

  assign recip_prod = y_pipe_r[1] * RECIP_127;
  assign tf_nxt     = (TF_W'(c0) <<< (FRAC_BITS - 1)) + c1 * t_pipe_r[1];

  // stage 3: the estimate is low by at most one, fix it with the remainder
  logic [Y_W-1:0]           q_x127;
  logic [Y_W-1:0]           rem;
  logic                     q_fix;
  logic signed [TEMP_W-1:0] temp_nxt;

  assign q_x127   = (Y_W'(s2_q0_r) << 7) - Y_W'(s2_q0_r);
  assign rem      = y_pipe_r[2] - q_x127;
  assign q_fix    = rem >= Y_W'(127);
  assign temp_nxt = TEMP_W'(trunc_frac(MUL_P_W'(s2_tf_r)));

  // stage 4: signed scaled pressure
  logic [Y_W-1:0]        pmag;
  logic signed [P_W-1:0] p_nxt;

  assign pmag  = y_pipe_r[3] + Y_W'(s3_q_r);
  assign p_nxt = pneg_pipe_r[3] ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});

  // stage 6: add offsets, truncate t*p
  logic signed [A_W-1:0]  a_nxt;
  logic signed [A_W-1:0]  f_nxt;
  logic signed [TP_W-1:0] tp_nxt;

  assign a_nxt  = (A_W'(c20_r) <<< FRAC_BITS) + A_W'(s5_ca_r);
  assign f_nxt  = (A_W'(c11_r) <<< FRAC_BITS) + A_W'(s5_cf_r);
  assign tp_nxt = TP_W'(trunc_frac(MUL_P_W'(s5_tpf_r)));

  // stages 7 and 8: p*a and tp*f in split multipliers
  logic signed [MUL_P_W-1:0] pa_prod;
  logic signed [MUL_P_W-1:0] g_prod;
  logic signed [MUL_P_W-1:0] pb_prod;

  psc_mul u_mul_pa (
    .clk  (clk),
    .en_a (adv[7]),
    .en_b (adv[8]),
    .x    (MUL_X_W'(p_pipe_r[6])),
    .y    (MUL_Y_W'(s6_a_r)),
    .prod (pa_prod)
  );

  psc_mul u_mul_g (
    .clk  (clk),
    .en_a (adv[7]),
    .en_b (adv[8]),
    .x    (MUL_X_W'(s6_tp_r)),
    .y    (MUL_Y_W'(s6_f_r)),
    .prod (g_prod)
  );

  // stage 9: b = c10 + p*a, g = tp*f
  logic signed [B_W-1:0] b_nxt;
  logic signed [G_W-1:0] g_nxt;

  assign b_nxt = (B_W'(c10) <<< FRAC_BITS) + B_W'(trunc_frac(pa_prod));
  assign g_nxt = G_W'(trunc_frac(g_prod));

  // stages 10 and 11: p*b
  psc_mul u_mul_pb (
    .clk  (clk),
    .en_a (adv[10]),
    .en_b (adv[11]),
    .x    (MUL_X_W'(p_pipe_r[9])),
    .y    (MUL_Y_W'(s9_b_r)),
    .prod (pb_prod)
  );

  // stage 12: d = c00 + p*b
  logic signed [D_W-1:0] d_nxt;

  assign d_nxt = (D_W'(c00) <<< FRAC_BITS) + D_W'(trunc_frac(pb_prod));

  // stage 13: sum of the three pressure terms
  logic signed [SUM_W-1:0] sum_nxt;

  assign sum_nxt = SUM_W'(s12_d_r) + SUM_W'(e_pipe_r[12]) + SUM_W'(g_pipe_r[12]);

  // output: integer part, clamp to 32 bits
  logic signed [PI_W-1:0]    pi;
  logic signed [PRESS_W-1:0] press_nxt;
  logic                      clip_nxt;

  assign pi = PI_W'(trunc_frac(MUL_P_W'(s13_sum_r)));

  always_comb begin
    priority if (pi > PI_MAX) begin
      press_nxt = PRESS_W'(PI_MAX);
      clip_nxt  = 1'b1;
    end else if (pi < PI_MIN) begin
      press_nxt = PRESS_W'(PI_MIN);
      clip_nxt  = 1'b1;
    end else begin
      press_nxt = PRESS_W'(pi);
      clip_nxt  = 1'b0;
    end
  end

  logic signed [TEMP_W-1:0]  out_temp_r;
  logic signed [PRESS_W-1:0] out_press_r;
  logic                      out_clip_r;

  // payload registers, each loads with its stage
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      t_pipe_r[1]    <= t_nxt;
      y_pipe_r[1]    <= y_nxt;
      pneg_pipe_r[1] <= in_raw_pressure[RAW_W-1];
    end
    if (adv[2]) begin
      s2_q0_r        <= recip_prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
      s2_tf_r        <= tf_nxt;
      t_pipe_r[2]    <= t_pipe_r[1];
      y_pipe_r[2]    <= y_pipe_r[1];
      pneg_pipe_r[2] <= pneg_pipe_r[1];
    end
    if (adv[3]) begin
      s3_q_r         <= s2_q0_r + Q_W'(q_fix);
      temp_pipe_r[3] <= temp_nxt;
      t_pipe_r[3]    <= t_pipe_r[2];
      y_pipe_r[3]    <= y_pipe_r[2];
      pneg_pipe_r[3] <= pneg_pipe_r[2];
    end
    if (adv[4]) begin
      p_pipe_r[4] <= p_nxt;
      t_pipe_r[4] <= t_pipe_r[3];
    end
    if (adv[5]) begin
      s5_ca_r     <= c30_r * p_pipe_r[4];
      s5_cf_r     <= c21_r * p_pipe_r[4];
      s5_tpf_r    <= t_pipe_r[4] * p_pipe_r[4];
      e_pipe_r[5] <= c01_r * t_pipe_r[4];
    end
    if (adv[6]) begin
      s6_a_r  <= a_nxt;
      s6_f_r  <= f_nxt;
      s6_tp_r <= tp_nxt;
    end
    if (adv[9]) begin
      s9_b_r      <= b_nxt;
      g_pipe_r[9] <= g_nxt;
    end
    if (adv[12]) begin
      s12_d_r <= d_nxt;
    end
    if (adv[13]) begin
      s13_sum_r <= sum_nxt;
    end
    if (adv[NSTG+1]) begin
      out_temp_r  <= temp_pipe_r[NSTG];
      out_press_r <= press_nxt;
      out_clip_r  <= clip_nxt;
    end
    // carried fields
    for (int i = 4; i <= NSTG; i++) begin
      if (adv[i]) begin
        temp_pipe_r[i] <= temp_pipe_r[i-1];
      end
    end
    for (int i = 5; i <= 9; i++) begin
      if (adv[i]) begin
        p_pipe_r[i] <= p_pipe_r[i-1];
      end
    end
    for (int i = 6; i <= 12; i++) begin
      if (adv[i]) begin
        e_pipe_r[i] <= e_pipe_r[i-1];
      end
    end
    for (int i = 10; i <= 12; i++) begin
      if (adv[i]) begin
        g_pipe_r[i] <= g_pipe_r[i-1];
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_temperature      = out_temp_r;
  assign out_pressure         = out_press_r;
  assign out_pressure_clipped = out_clip_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // a clipped word sits exactly on one of the 32-bit limits
  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clip_r |->
      (out_press_r == PRESS_W'(PI_MAX) || out_press_r == PRESS_W'(PI_MIN)))
    else $error("clipped pressure not at a 32-bit limit");

  // compensated temperature stays within what the coefficients allow
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_temp_r >= -17'sd33792 && out_temp_r <= 17'sd33792))
    else $error("temperature out of range");

  // with the output register empty every stage can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

  // reset empties the whole pipeline
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0) && !out_valid_r)
    else $error("pipeline not empty after reset");

endmodule
